// ===== design/rae_pkg.sv =====
// Package with shared types, constants and the attribute kind table.
`default_nettype none
package rae_pkg;

  // Header plus authenticator size in bytes.
  localparam logic [15:0] HDR_TOTAL = 16'd20;

  // Kind of each result record.
  typedef enum logic [1:0] {
    REC_HEADER    = 2'd0,
    REC_ATTR      = 2'd1,
    REC_NO_ATTR   = 2'd2,
    REC_FRAME_END = 2'd3
  } rec_kind_t;

  // One result record, without the run marker.
  typedef struct packed {
    rec_kind_t   record_kind;
    logic [7:0]  packet_code;
    logic [7:0]  packet_ident;
    logic [15:0] packet_length;
    logic [7:0]  attr_type;
    logic [7:0]  attr_length;
    logic [4:0]  value_kind;
    logic [31:0] value_word;
    logic [15:0] attr_offset;
    logic        truncated;
  } rec_t;

  // Value kind for attribute types below 64; higher types have kind 0.
  localparam logic [4:0] KIND_TABLE [64] = '{
    5'd0, 5'd1, 5'd2, 5'd2, 5'd4, 5'd3, 5'd5, 5'd6,
    5'd4, 5'd4, 5'd7, 5'd1, 5'd3, 5'd8, 5'd4, 5'd9,
    5'd3, 5'd10, 5'd1, 5'd2, 5'd2, 5'd10, 5'd1, 5'd11,
    5'd2, 5'd2, 5'd2, 5'd3, 5'd3, 5'd12, 5'd2, 5'd2,
    5'd2, 5'd2, 5'd2, 5'd2, 5'd2, 5'd3, 5'd3, 5'd2,
    5'd13, 5'd3, 5'd3, 5'd3, 5'd1, 5'd14, 5'd3, 5'd3,
    5'd3, 5'd15, 5'd1, 5'd3, 5'd0, 5'd0, 5'd0, 5'd0,
    5'd0, 5'd0, 5'd0, 5'd0, 5'd2, 5'd16, 5'd3, 5'd2
  };

  // Control between the input stage and the record emitter.
  typedef struct packed {
    logic held;
    logic release_item;
  } stage_ctl_t;

endpackage
`default_nettype wire

// ===== design/rae_if.sv =====
// Channel interfaces for message bytes and result records.
`default_nettype none
interface rae_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       frame_last;

  modport source (output valid, output data_byte, output frame_last, input ready);
  modport sink (input valid, input data_byte, input frame_last, output ready);
endinterface

interface rae_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  record_kind;
  logic [7:0]  packet_code;
  logic [7:0]  packet_ident;
  logic [15:0] packet_length;
  logic [7:0]  attr_type;
  logic [7:0]  attr_length;
  logic [4:0]  value_kind;
  logic [31:0] value_word;
  logic [15:0] attr_offset;
  logic        truncated;
  logic        last_of_run;

  modport source (
    output valid, output record_kind, output packet_code, output packet_ident,
    output packet_length, output attr_type, output attr_length, output value_kind,
    output value_word, output attr_offset, output truncated, output last_of_run,
    input ready
  );
  modport sink (
    input valid, input record_kind, input packet_code, input packet_ident,
    input packet_length, input attr_type, input attr_length, input value_kind,
    input value_word, input attr_offset, input truncated, input last_of_run,
    output ready
  );
endinterface
`default_nettype wire

// ===== design/rae_in_stage.sv =====
// Input register that holds one message byte until its records are issued.
`default_nettype none
module rae_in_stage (
  input  wire logic       clk,
  input  wire logic       rst,
  rae_in_if.sink          in_ch,
  input  wire logic       release_item,
  output rae_pkg::stage_ctl_t ctl,
  output logic [7:0]      data_byte,
  output logic            frame_last
);
  import rae_pkg::*;

  logic held;

  // A new byte enters when the stage is empty or its byte leaves this cycle.
  assign in_ch.ready      = !held || release_item;
  assign ctl.held         = held;
  assign ctl.release_item = release_item;

  always_ff @(posedge clk) begin
    if (rst) begin
      held <= 1'b0;
    end else if (in_ch.valid && in_ch.ready) begin
      held <= 1'b1;
    end else if (release_item) begin
      held <= 1'b0;
    end
  end

  // Payload needs no reset.
  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      data_byte  <= in_ch.data_byte;
      frame_last <= in_ch.frame_last;
    end
  end
endmodule
`default_nettype wire

// ===== design/rae_walker.sv =====
// Message walker: parse state and the records caused by the held byte.
`default_nettype none
module rae_walker (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire rae_pkg::stage_ctl_t ctl,
  input  wire logic [7:0]  data_byte,
  input  wire logic        frame_last,
  output rae_pkg::rec_t [2:0] recs,
  output logic [2:0]       rec_mask
);
  import rae_pkg::*;

  typedef struct packed {
    logic [15:0]        pos;
    logic               pos_ovf;
    logic [7:0]         code;
    logic [7:0]         ident;
    logic [15:0]        length;
    logic signed [16:0] budget;
    logic [15:0]        start;
    logic [7:0]         atype;
    logic [7:0]         alen;
    logic [31:0]        accum;
    logic               done;
  } wstate_t;

  wstate_t     st;
  wstate_t     st_next;
  logic [15:0] off;
  logic        hdr_now;
  logic        noattr_now;
  logic        attr_now;
  logic        emit;
  logic [31:0] byte_shifted;
  rec_t        hdr_rec;
  rec_t        attr_rec;
  rec_t        noattr_rec;
  rec_t        end_rec;

  assign off = st.pos - st.start;

  // Value byte placed big-endian by its offset inside the attribute.
  always_comb begin
    unique case (off[2:0])
      3'd2:    byte_shifted = {data_byte, 24'h000000};
      3'd3:    byte_shifted = {8'h00, data_byte, 16'h0000};
      3'd4:    byte_shifted = {16'h0000, data_byte, 8'h00};
      3'd5:    byte_shifted = {24'h000000, data_byte};
      default: byte_shifted = 32'h0;
    endcase
  end

  // Next parse state for the held byte.
  always_comb begin
    st_next    = st;
    hdr_now    = 1'b0;
    noattr_now = 1'b0;
    attr_now   = 1'b0;
    emit       = 1'b0;
    if (!st.pos_ovf) begin
      priority if (st.pos == 16'd0) begin
        st_next.code = data_byte;
      end else if (st.pos == 16'd1) begin
        st_next.ident = data_byte;
      end else if (st.pos == 16'd2) begin
        st_next.length = {data_byte, 8'h00};
      end else if (st.pos == 16'd3) begin
        st_next.length = {st.length[15:8], data_byte};
        st_next.budget = $signed({1'b0, st_next.length}) - $signed({1'b0, HDR_TOTAL});
        st_next.start  = HDR_TOTAL;
        hdr_now        = 1'b1;
        noattr_now     = (st_next.budget == 17'sd0);
        if (st_next.budget <= 17'sd0) begin
          st_next.done = 1'b1;
        end
      end else if (st.pos >= HDR_TOTAL && !st.done && st.pos >= st.start) begin
        priority if (off == 16'd0) begin
          st_next.atype = data_byte;
          st_next.accum = 32'h0;
        end else if (off == 16'd1) begin
          st_next.alen   = data_byte;
          st_next.budget = st.budget - $signed({9'b0, data_byte});
          if (data_byte < 8'd2) begin
            attr_now     = 1'b1;
            st_next.done = 1'b1;
          end else if (data_byte == 8'd2) begin
            emit = 1'b1;
          end
        end else begin
          if (off <= 16'd5) begin
            st_next.accum = st.accum | byte_shifted;
          end
          if (off == {8'h00, st.alen - 8'd1}) begin
            emit = 1'b1;
          end
        end
        if (emit) begin
          attr_now      = 1'b1;
          st_next.start = st.start + {8'h00, st_next.alen};
          if (st_next.budget <= 17'sd0) begin
            st_next.done = 1'b1;
          end
        end
      end else begin
        st_next.pos_ovf = st.pos_ovf;
      end
    end
    // Byte position saturates at its top value.
    if (st.pos == 16'hFFFF) begin
      st_next.pos_ovf = 1'b1;
    end else begin
      st_next.pos = st.pos + 16'd1;
    end
  end

  // Records built from the updated header and attribute values.
  always_comb begin
    hdr_rec               = '0;
    hdr_rec.record_kind   = REC_HEADER;
    hdr_rec.packet_code   = st_next.code;
    hdr_rec.packet_ident  = st_next.ident;
    hdr_rec.packet_length = st_next.length;

    noattr_rec             = hdr_rec;
    noattr_rec.record_kind = REC_NO_ATTR;
    noattr_rec.attr_offset = HDR_TOTAL;

    attr_rec             = hdr_rec;
    attr_rec.record_kind = REC_ATTR;
    attr_rec.attr_type   = st_next.atype;
    attr_rec.attr_length = st_next.alen;
    attr_rec.value_kind  = (st_next.atype < 8'd64) ? KIND_TABLE[st_next.atype[5:0]] : 5'd0;
    attr_rec.value_word  = st_next.accum;
    attr_rec.attr_offset = st.start;

    end_rec             = hdr_rec;
    end_rec.record_kind = REC_FRAME_END;
    end_rec.attr_offset = st.pos;
    end_rec.truncated   = !st_next.done;
  end

  assign recs[0]  = hdr_now ? hdr_rec : attr_rec;
  assign recs[1]  = noattr_rec;
  assign recs[2]  = end_rec;
  assign rec_mask = {frame_last, noattr_now, hdr_now || attr_now};

  // State advances when the held byte leaves; a frame end starts over.
  always_ff @(posedge clk) begin
    if (rst) begin
      st <= '0;
    end else if (ctl.held && ctl.release_item) begin
      if (frame_last) begin
        st <= '0;
      end else begin
        st <= st_next;
      end
    end
  end
endmodule
`default_nettype wire

// ===== design/rae_emitter.sv =====
// Record emitter: issues the held byte's records one per transaction.
`default_nettype none
module rae_emitter (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       held,
  input  wire rae_pkg::rec_t [2:0] recs,
  input  wire logic [2:0] rec_mask,
  output logic            release_item,
  rae_out_if.source       out_ch
);
  import rae_pkg::*;

  logic [2:0] sent;
  logic [2:0] pending;
  logic [2:0] pick;
  logic [1:0] pick_idx;
  logic       single;
  logic       out_free;
  logic       load;
  logic       out_valid;
  rec_t       out_rec;
  logic       out_last;

  assign pending  = rec_mask & ~sent;
  assign single   = ((pending & (pending - 3'd1)) == 3'd0);
  assign out_free = !out_valid || out_ch.ready;
  assign load     = held && (pending != 3'd0) && out_free;
  assign release_item = held && ((pending == 3'd0) || (load && single));

  // Records leave in the order header or attribute, no attributes, frame end.
  always_comb begin
    priority if (pending[0]) begin
      pick = 3'b001; pick_idx = 2'd0;
    end else if (pending[1]) begin
      pick = 3'b010; pick_idx = 2'd1;
    end else begin
      pick = 3'b100; pick_idx = 2'd2;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sent      <= 3'b000;
      out_valid <= 1'b0;
    end else begin
      if (release_item) begin
        sent <= 3'b000;
      end else if (load) begin
        sent <= sent | pick;
      end
      if (load) begin
        out_valid <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Output register payload.
  always_ff @(posedge clk) begin
    if (load) begin
      out_rec  <= recs[pick_idx];
      out_last <= single;
    end
  end

  assign out_ch.valid         = out_valid;
  assign out_ch.record_kind   = out_rec.record_kind;
  assign out_ch.packet_code   = out_rec.packet_code;
  assign out_ch.packet_ident  = out_rec.packet_ident;
  assign out_ch.packet_length = out_rec.packet_length;
  assign out_ch.attr_type     = out_rec.attr_type;
  assign out_ch.attr_length   = out_rec.attr_length;
  assign out_ch.value_kind    = out_rec.value_kind;
  assign out_ch.value_word    = out_rec.value_word;
  assign out_ch.attr_offset   = out_rec.attr_offset;
  assign out_ch.truncated     = out_rec.truncated;
  assign out_ch.last_of_run   = out_last;
endmodule
`default_nettype wire

// ===== design/radius_attribute_extractor.sv =====
// Top level of the RADIUS attribute extractor.
//
//  Channel  Role    Carries
//  in_ch    sink    one message byte and a frame end flag per transaction
//  out_ch   source  one header, attribute, no-attributes or frame end record
//
// A byte is taken into the input register, its records are formed by the
// walker and issued through the output register. A byte that causes
// several records (up to 3) occupies the input register until its last
// record is loaded; others pass at one per cycle while the output is free.
// Reset clears the parse state and both stage valid flags.
// A stalled output holds its record and the input register, which then
// stops taking bytes.
`default_nettype none
module radius_attribute_extractor (
  input wire logic  clk,
  input wire logic  rst,
  rae_in_if.sink    in_ch,
  rae_out_if.source out_ch
);
  import rae_pkg::*;

  stage_ctl_t      ctl;
  logic            release_item;
  logic [7:0]      data_byte;
  logic            frame_last;
  rec_t [2:0]      recs;
  logic [2:0]      rec_mask;

  rae_in_stage u_in_stage (
    .clk          (clk),
    .rst          (rst),
    .in_ch        (in_ch),
    .release_item (release_item),
    .ctl          (ctl),
    .data_byte    (data_byte),
    .frame_last   (frame_last)
  );

  rae_walker u_walker (
    .clk        (clk),
    .rst        (rst),
    .ctl        (ctl),
    .data_byte  (data_byte),
    .frame_last (frame_last),
    .recs       (recs),
    .rec_mask   (rec_mask)
  );

  rae_emitter u_emitter (
    .clk          (clk),
    .rst          (rst),
    .held         (ctl.held),
    .recs         (recs),
    .rec_mask     (rec_mask),
    .release_item (release_item),
    .out_ch       (out_ch)
  );
endmodule
`default_nettype wire

// ===== tb/rae_tb_pkg.sv =====
// Scoreboard class that predicts and checks the extractor's result records.
`timescale 1ns / 1ps
package rae_tb_pkg;
  import rae_pkg::*;

  // One predicted record together with its run marker.
  typedef struct packed {
    rec_t rec;
    logic last_of_run;
  } rec_run_t;

  class rae_scoreboard;
    // Parse state mirrored from the block.
    logic [15:0] byte_pos;
    bit          pos_sat;
    logic [7:0]  code;
    logic [7:0]  ident;
    logic [15:0] msg_len;
    int          budget;
    logic [15:0] attr_start;
    logic [7:0]  attr_type;
    logic [7:0]  attr_len;
    logic [31:0] value_acc;
    bit          walk_done;

    rec_run_t pending_records[$];
    int       records_predicted;
    int       failures;

    function new();
      clear_parse();
      records_predicted = 0;
      failures = 0;
    endfunction

    // State at reset and after every frame end.
    function void clear_parse();
      byte_pos = '0;
      pos_sat = 1'b0;
      code = '0;
      ident = '0;
      msg_len = '0;
      budget = 0;
      attr_start = '0;
      attr_type = '0;
      attr_len = '0;
      value_acc = '0;
      walk_done = 1'b0;
    endfunction

    // Builds one record from the current state and queues it.
    function void queue_record(rec_kind_t kind, logic [15:0] offs, logic trunc);
      rec_run_t r;
      bit is_attr;
      is_attr = (kind == REC_ATTR);
      r.rec.record_kind = kind;
      r.rec.packet_code = code;
      r.rec.packet_ident = ident;
      r.rec.packet_length = msg_len;
      r.rec.attr_type = is_attr ? attr_type : 8'd0;
      r.rec.attr_length = is_attr ? attr_len : 8'd0;
      r.rec.value_kind = (is_attr && attr_type < 8'd64) ? KIND_TABLE[attr_type[5:0]] : 5'd0;
      r.rec.value_word = is_attr ? value_acc : 32'd0;
      r.rec.attr_offset = offs;
      r.rec.truncated = trunc;
      r.last_of_run = 1'b0;
      pending_records.push_back(r);
      records_predicted++;
    endfunction

    // Advances the parse by one accepted byte and queues the records it causes.
    function void take_byte(logic [7:0] b, logic lst);
      logic [15:0] p;
      int unsigned off;
      bit close_attr;
      int queued_at_entry;
      p = byte_pos;
      queued_at_entry = pending_records.size();
      close_attr = 1'b0;

      if (!pos_sat) begin
        if (p == 16'd0) begin
          code = b;
        end else if (p == 16'd1) begin
          ident = b;
        end else if (p == 16'd2) begin
          msg_len = {b, 8'h00};
        end else if (p == 16'd3) begin
          msg_len[7:0] = b;
          budget = int'(msg_len) - int'(HDR_TOTAL);
          attr_start = HDR_TOTAL;
          queue_record(REC_HEADER, 16'd0, 1'b0);
          if (budget == 0) queue_record(REC_NO_ATTR, HDR_TOTAL, 1'b0);
          if (budget <= 0) walk_done = 1'b1;
        end else if (p >= HDR_TOTAL && !walk_done && p >= attr_start) begin
          off = int'(p) - int'(attr_start);
          if (off == 0) begin
            attr_type = b;
            value_acc = '0;
          end else if (off == 1) begin
            attr_len = b;
            budget -= int'(b);
            if (b < 8'd2) begin
              // A zero or one length byte closes the attribute and stops the walk.
              queue_record(REC_ATTR, attr_start, 1'b0);
              walk_done = 1'b1;
            end else if (b == 8'd2) begin
              close_attr = 1'b1;
            end
          end else begin
            if (off <= 5) value_acc |= 32'(b) << (8 * (5 - off));
            if (int'(off) == int'(attr_len) - 1) close_attr = 1'b1;
          end
          if (close_attr) begin
            queue_record(REC_ATTR, attr_start, 1'b0);
            attr_start = attr_start + 16'(attr_len);
            if (budget <= 0) walk_done = 1'b1;
          end
        end
      end

      if (lst) queue_record(REC_FRAME_END, p, !walk_done);
      if (pending_records.size() > queued_at_entry) begin
        pending_records[pending_records.size() - 1].last_of_run = 1'b1;
      end

      // Frame end restarts the parse; otherwise the position saturates.
      if (lst) begin
        clear_parse();
      end else if (p == 16'hFFFF) begin
        pos_sat = 1'b1;
      end else begin
        byte_pos = p + 16'd1;
      end
    endfunction

    // Compares one accepted record with the oldest prediction.
    function void check_record(rec_t got, logic got_last);
      rec_run_t want;
      string diffs;
      if (pending_records.size() == 0) begin
        failures++;
        if (failures <= 10) $display("unexpected record: %p last_of_run=%b", got, got_last);
        return;
      end
      want = pending_records.pop_front();
      diffs = "";
      if (got.record_kind !== want.rec.record_kind) diffs = {diffs, " record_kind"};
      if (got.packet_code !== want.rec.packet_code) diffs = {diffs, " packet_code"};
      if (got.packet_ident !== want.rec.packet_ident) diffs = {diffs, " packet_ident"};
      if (got.packet_length !== want.rec.packet_length) diffs = {diffs, " packet_length"};
      if (got.attr_type !== want.rec.attr_type) diffs = {diffs, " attr_type"};
      if (got.attr_length !== want.rec.attr_length) diffs = {diffs, " attr_length"};
      if (got.value_kind !== want.rec.value_kind) diffs = {diffs, " value_kind"};
      if (got.value_word !== want.rec.value_word) diffs = {diffs, " value_word"};
      if (got.attr_offset !== want.rec.attr_offset) diffs = {diffs, " attr_offset"};
      if (got.truncated !== want.rec.truncated) diffs = {diffs, " truncated"};
      if (got_last !== want.last_of_run) diffs = {diffs, " last_of_run"};
      if (diffs != "") begin
        failures++;
        if (failures <= 10) begin
          $display("record mismatch in%s", diffs);
          $display("  expected %p last_of_run=%b", want.rec, want.last_of_run);
          $display("  actual   %p last_of_run=%b", got, got_last);
        end
      end
    endfunction
  endclass
endpackage

// ===== tb/radius_attribute_extractor_test.sv =====
// Top-level testbench: drives RADIUS byte streams and checks every result record.
`timescale 1ns / 1ps
module radius_attribute_extractor_test;
  import rae_pkg::*;
  import rae_tb_pkg::*;

  localparam int LONG_HOLD = 200;

  logic clk;
  logic rst;
  logic calm;
  int   hold_requests;
  int   holds_done;

  rae_in_if  in_ch ();
  rae_out_if out_ch ();

  rae_scoreboard sb;

  radius_attribute_extractor dut (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // Free-running 10 ns clock.
  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Idle length: mostly none or short, now and then long.
  function automatic int idle_cycles();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  // Appends a header and a random authenticator.
  function automatic void start_message(ref logic [7:0] q[$], input logic [7:0] c,
                                        input logic [7:0] id, input logic [15:0] len);
    q.push_back(c);
    q.push_back(id);
    q.push_back(len[15:8]);
    q.push_back(len[7:0]);
    repeat (16) q.push_back(8'($urandom));
  endfunction

  // Random message: mostly well-formed attribute lists, some broken or noise.
  function automatic void build_message(ref logic [7:0] q[$]);
    logic [7:0] body[$];
    int n_attr;
    int alen;
    int total;
    int r;
    logic [15:0] len;
    q.delete();
    if ($urandom_range(0, 99) < 12) begin
      repeat ($urandom_range(1, 30)) q.push_back(8'($urandom));
      return;
    end
    n_attr = $urandom_range(0, 3);
    for (int i = 0; i < n_attr; i++) begin
      r = $urandom_range(0, 99);
      if (r < 6) alen = $urandom_range(0, 1);
      else if (r < 80) alen = $urandom_range(2, 8);
      else alen = $urandom_range(9, 40);
      body.push_back($urandom_range(0, 1) ? 8'($urandom_range(0, 63)) : 8'($urandom));
      body.push_back(8'(alen));
      for (int k = 2; k < alen; k++) body.push_back(8'($urandom));
    end
    total = 20 + body.size();
    r = $urandom_range(0, 99);
    if (r < 70) len = 16'(total);
    else if (r < 80) len = 16'(total - $urandom_range(1, 6));
    else if (r < 88) len = 16'(total + $urandom_range(1, 10));
    else if (r < 93) len = 16'($urandom_range(0, 19));
    else len = 16'($urandom);
    start_message(q, 8'($urandom), 8'($urandom), len);
    foreach (body[i]) q.push_back(body[i]);
    if ($urandom_range(0, 99) < 15) repeat ($urandom_range(1, 5)) q.push_back(8'($urandom));
    if ($urandom_range(0, 99) < 15 && q.size() > 1) begin
      q = q[0:$urandom_range(0, q.size() - 2)];
    end
  endfunction

  // Offers one byte after an optional gap and waits for its transaction.
  task automatic send_byte(input logic [7:0] b, input logic lst);
    int gap;
    gap = calm ? 0 : idle_cycles();
    repeat (gap) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.data_byte <= b;
    in_ch.frame_last <= lst;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    sb.take_byte(b, lst);
  endtask

  task automatic send_frame(input logic [7:0] q[$]);
    foreach (q[i]) send_byte(q[i], i == q.size() - 1);
  endtask

  // Accepted output transactions go to the scoreboard.
  always @(posedge clk) begin
    rec_t got;
    if (!rst && out_ch.valid === 1'b1 && out_ch.ready) begin
      got.record_kind = rec_kind_t'(out_ch.record_kind);
      got.packet_code = out_ch.packet_code;
      got.packet_ident = out_ch.packet_ident;
      got.packet_length = out_ch.packet_length;
      got.attr_type = out_ch.attr_type;
      got.attr_length = out_ch.attr_length;
      got.value_kind = out_ch.value_kind;
      got.value_word = out_ch.value_word;
      got.attr_offset = out_ch.attr_offset;
      got.truncated = out_ch.truncated;
      sb.check_record(got, out_ch.last_of_run);
    end
  end

  // Receiver: random stalls, full speed while calm, one long hold on request.
  initial begin
    int stall;
    stall = 0;
    holds_done = 0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_requests != holds_done) begin
        out_ch.ready <= 1'b0;
        repeat (LONG_HOLD - 1) @(posedge clk);
        holds_done++;
      end else if (stall > 0) begin
        out_ch.ready <= 1'b0;
        stall--;
      end else begin
        out_ch.ready <= 1'b1;
        if (!calm && $urandom_range(0, 2) == 0) stall = idle_cycles();
      end
    end
  end

  // Stimulus, drain and verdict.
  initial begin
    logic [7:0] frame[$];
    int sent;
    int waited;
    sb = new();
    rst <= 1'b1;
    calm <= 1'b0;
    hold_requests <= 0;
    in_ch.valid <= 1'b0;
    in_ch.data_byte <= 8'h00;
    in_ch.frame_last <= 1'b0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // Frames that end inside the header.
    frame = '{8'h00};
    send_frame(frame);
    frame = '{8'hFF, 8'hFF, 8'hFF, 8'hFF};
    send_frame(frame);
    frame = '{8'h00, 8'h00, 8'h00, 8'h00};
    send_frame(frame);
    // Empty list: header, no-attributes and frame end from one byte.
    frame = '{8'h01, 8'h80, 8'h00, 8'h14};
    send_frame(frame);

    // Budget used up exactly, then bytes after the walk.
    frame.delete();
    start_message(frame, 8'h01, 8'h00, 16'd29);
    frame = {frame, 8'h00, 8'h03, 8'hA5, 8'h3F, 8'h06, 8'hDE, 8'hAD, 8'hBE, 8'hEF,
             8'h11, 8'h22};
    send_frame(frame);
    // Length two attribute, then a length one attribute that ends the walk.
    frame.delete();
    start_message(frame, 8'hFF, 8'h7F, 16'h0100);
    frame = {frame, 8'hFF, 8'h02, 8'h40, 8'h01, 8'h00};
    send_frame(frame);
    // Length zero attribute.
    frame.delete();
    start_message(frame, 8'h0B, 8'h01, 16'h0020);
    frame = {frame, 8'h1A, 8'h00, 8'hFF};
    send_frame(frame);

    // Random messages; the long receiver hold falls in the first of them.
    hold_requests <= hold_requests + 1;
    sent = 0;
    while (sent < 110) begin
      calm <= ($urandom_range(0, 4) == 0);
      build_message(frame);
      send_frame(frame);
      sent += frame.size();
    end
    in_ch.valid <= 1'b0;

    // Wait for outstanding records, then a few cycles for strays.
    waited = 0;
    while (sb.pending_records.size() != 0 && waited < 100000) begin
      @(posedge clk);
      waited++;
    end
    repeat (20) @(posedge clk);
    if (sb.pending_records.size() != 0) begin
      $display("%0d expected records never arrived", sb.pending_records.size());
    end

    if (sb.failures == 0 && sb.pending_records.size() == 0) begin
      $display("radius_attribute_extractor_test: PASS");
    end else begin
      $display("radius_attribute_extractor_test: FAIL");
    end
    $finish;
  end

  // Watchdog for a hung handshake.
  initial begin
    #400_000_000;
    $display("radius_attribute_extractor_test: FAIL");
    $finish;
  end
endmodule
